### sv/vrp_pkg.sv
// Shared types, constants and arithmetic helpers for the vertex rotate/project block.
`timescale 1ns / 1ps
package vrp_pkg;

  localparam int CoordW   = 24;
  localparam int TrigW    = 16;
  localparam int DistW    = 23;
  localparam int ScreenW  = 16;
  localparam int NumRegs  = 7;
  localparam int RegIdxW  = 3;
  localparam int CfgDataW = 23;
  localparam int DefScreenWidth  = 512;
  localparam int DefScreenHeight = 512;

  // Division pipeline: 48-bit magnitude numerator, 33-bit divisor.
  localparam int NumW = 48;
  localparam int DenW = 33;

  typedef enum logic [RegIdxW-1:0] {
    REG_X_COS  = 3'd0,
    REG_X_SIN  = 3'd1,
    REG_Y_COS  = 3'd2,
    REG_Y_SIN  = 3'd3,
    REG_Z_COS  = 3'd4,
    REG_Z_SIN  = 3'd5,
    REG_VIEW_D = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic signed [CoordW-1:0] vertex_x;
    logic signed [CoordW-1:0] vertex_y;
    logic signed [CoordW-1:0] vertex_z;
    logic                     last_vertex;
  } vrp_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0]  rotated_x;
    logic signed [CoordW-1:0]  rotated_y;
    logic signed [CoordW-1:0]  rotated_z;
    logic signed [ScreenW-1:0] screen_x;
    logic signed [ScreenW-1:0] screen_y;
    logic                      behind_viewer;
    logic                      saturated;
    logic                      last_out;
  } vrp_out_t;

  typedef struct packed {
    logic signed [TrigW-1:0] x_cos;
    logic signed [TrigW-1:0] x_sin;
    logic signed [TrigW-1:0] y_cos;
    logic signed [TrigW-1:0] y_sin;
    logic signed [TrigW-1:0] z_cos;
    logic signed [TrigW-1:0] z_sin;
    logic [DistW-1:0]        view_d;
  } vrp_cfg_t;

  // Item handed from the rotation front to the projection back.
  typedef struct packed {
    logic signed [CoordW-1:0] rx;
    logic signed [CoordW-1:0] ry;
    logic signed [CoordW-1:0] rz;
    logic                     sat;
    logic                     last;
  } vrp_rot_t;

  // Round (+8192 >> 14) and clamp one 41-bit rotation sum to 24 bits.
  function automatic logic [CoordW:0] rot_round(input logic signed [40:0] acc);
    logic signed [40:0] r;
    logic signed [26:0] q;
    r = acc + 41'sd8192;
    q = r[40:14];
    if (q > 27'sd8388607)       rot_round = {1'b1, 24'h7FFFFF};
    else if (q < -27'sd8388608) rot_round = {1'b1, 24'h800000};
    else                        rot_round = {1'b0, q[CoordW-1:0]};
  endfunction

endpackage

### sv/vrp_rotate.sv
// Front: three registered rotation stages (X, Y, Z) with round and clamp.
`timescale 1ns / 1ps
module vrp_rotate
  import vrp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  vrp_in_t  item_i,
  input  vrp_cfg_t cfg_i,
  output logic     valid_o,
  output vrp_rot_t item_o
);

  // stage registers: valid shifts when enabled
  logic [2:0] vld_q;
  logic signed [CoordW-1:0] x1_q, y1_q, z1_q, x2_q, y2_q, z2_q;
  logic sat1_q, sat2_q, last1_q, last2_q;
  vrp_rot_t out_q;

  logic [CoordW:0] a1, b1, a2, b2, a3, b3;

  // X axis: y' = y c - z s, z' = z c + y s
  assign a1 = rot_round(41'(item_i.vertex_y * cfg_i.x_cos) - 41'(item_i.vertex_z * cfg_i.x_sin));
  assign b1 = rot_round(41'(item_i.vertex_z * cfg_i.x_cos) + 41'(item_i.vertex_y * cfg_i.x_sin));
  // Y axis: x' = x c + z s, z' = z c - x s
  assign a2 = rot_round(41'(x1_q * cfg_i.y_cos) + 41'(z1_q * cfg_i.y_sin));
  assign b2 = rot_round(41'(z1_q * cfg_i.y_cos) - 41'(x1_q * cfg_i.y_sin));
  // Z axis: x' = x c - y s, y' = y c + x s
  assign a3 = rot_round(41'(x2_q * cfg_i.z_cos) - 41'(y2_q * cfg_i.z_sin));
  assign b3 = rot_round(41'(y2_q * cfg_i.z_cos) + 41'(x2_q * cfg_i.z_sin));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q    <= item_i.vertex_x;
      y1_q    <= a1[CoordW-1:0];
      z1_q    <= b1[CoordW-1:0];
      sat1_q  <= a1[CoordW] | b1[CoordW];
      last1_q <= item_i.last_vertex;
      x2_q    <= a2[CoordW-1:0];
      y2_q    <= y1_q;
      z2_q    <= b2[CoordW-1:0];
      sat2_q  <= sat1_q | a2[CoordW] | b2[CoordW];
      last2_q <= last1_q;
      out_q.rx   <= a3[CoordW-1:0];
      out_q.ry   <= b3[CoordW-1:0];
      out_q.rz   <= z2_q;
      out_q.sat  <= sat2_q | a3[CoordW] | b3[CoordW];
      out_q.last <= last2_q;
    end
  end

  assign valid_o = vld_q[2];
  assign item_o  = out_q;

endmodule

### sv/vrp_fifo.sv
// Small queue between the rotation front and the projection back.
`timescale 1ns / 1ps
module vrp_fifo
  import vrp_pkg::*;
#(
  parameter int Depth = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  vrp_rot_t data_i,
  input  logic     pop_i,
  output logic     empty_o,
  output logic [$clog2(Depth+1)-1:0] count_o,
  output vrp_rot_t data_o
);

  localparam int PtrW = $clog2(Depth);

  vrp_rot_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [$clog2(Depth+1)-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + {{($bits(cnt_q)-1){1'b0}}, push_i} - {{($bits(cnt_q)-1){1'b0}}, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  assign data_o  = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

endmodule

### sv/vrp_project.sv
// Back: pipelined perspective divide, one quotient bit per stage, then centering and clamp.
`timescale 1ns / 1ps
module vrp_project
  import vrp_pkg::*;
#(
  parameter int ScreenWidth  = DefScreenWidth,
  parameter int ScreenHeight = DefScreenHeight
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  vrp_rot_t item_i,
  input  logic [DistW-1:0] view_d_i,
  output logic     valid_o,
  output vrp_out_t item_o
);

  // Stage P0: products and divisor.
  localparam int QW = NumW;          // quotient bits resolved (numerator magnitude width)
  localparam int Lat = QW + 2;       // P0, QW divide steps, final

  typedef struct packed {
    logic [NumW-1:0] rem_x;
    logic [NumW-1:0] rem_y;
    logic [NumW-1:0] qx;
    logic [NumW-1:0] qy;
    logic            nx;
    logic            ny;
    logic [DenW-1:0] den;
    logic            behind;
    vrp_rot_t        rot;
  } dstage_t;

  dstage_t st_q [QW+1];
  logic [Lat-1:0] vld_q;
  vrp_out_t out_q;

  // P0 combinational: num = r * d (48-bit signed), den = (rz + d) * 256
  logic signed [CoordW+DistW:0] px_full, py_full;
  logic signed [CoordW+1:0]     den_s;
  logic [NumW-1:0]              mag_x, mag_y;
  dstage_t s0;

  always_comb begin
    px_full = item_i.rx * $signed({1'b0, view_d_i});
    py_full = item_i.ry * $signed({1'b0, view_d_i});
    den_s   = $signed({{2{item_i.rz[CoordW-1]}}, item_i.rz}) + $signed({3'b0, view_d_i});
    mag_x   = px_full[CoordW+DistW] ? NumW'(-px_full) : NumW'(px_full);
    mag_y   = py_full[CoordW+DistW] ? NumW'(-py_full) : NumW'(py_full);
    s0.rem_x  = '0;
    s0.rem_y  = '0;
    s0.qx     = mag_x;
    s0.qy     = mag_y;
    s0.nx     = px_full[CoordW+DistW];
    s0.ny     = py_full[CoordW+DistW];
    s0.den    = {den_s[DenW-9:0], 8'h00};
    s0.behind = (den_s <= 0);
    s0.rot    = item_i;
  end

  // restoring divide step: shift next numerator bit into remainder
  function automatic dstage_t div_step(input dstage_t s);
    dstage_t n;
    logic [NumW:0] tx, ty;
    n = s;
    tx = {s.rem_x, s.qx[NumW-1]} - {{(NumW+1-DenW){1'b0}}, s.den};
    ty = {s.rem_y, s.qy[NumW-1]} - {{(NumW+1-DenW){1'b0}}, s.den};
    n.rem_x = tx[NumW] ? {s.rem_x[NumW-2:0], s.qx[NumW-1]} : tx[NumW-1:0];
    n.rem_y = ty[NumW] ? {s.rem_y[NumW-2:0], s.qy[NumW-1]} : ty[NumW-1:0];
    n.qx = {s.qx[NumW-2:0], ~tx[NumW]};
    n.qy = {s.qy[NumW-2:0], ~ty[NumW]};
    div_step = n;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Lat-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= s0;
      for (int i = 1; i <= QW; i++) st_q[i] <= div_step(st_q[i-1]);
    end
  end

  // Final: apply floor sign, add center, clamp; zero the position when behind the viewer.
  logic signed [NumW+1:0] fx, fy, sx, sy;
  logic cx, cy;
  logic [ScreenW-1:0] scr_x, scr_y;
  dstage_t sf;

  always_comb begin
    sf = st_q[QW];
    fx = sf.nx ? -$signed({2'b0, sf.qx}) - $signed({{(NumW+1){1'b0}}, sf.rem_x != '0})
               :  $signed({2'b0, sf.qx});
    fy = sf.ny ? -$signed({2'b0, sf.qy}) - $signed({{(NumW+1){1'b0}}, sf.rem_y != '0})
               :  $signed({2'b0, sf.qy});
    sx = fx + (NumW+2)'(ScreenWidth / 2);
    sy = fy + (NumW+2)'(ScreenHeight / 2);
    cx = 1'b0;
    cy = 1'b0;
    if (sx > 32767)       begin scr_x = 16'h7FFF; cx = 1'b1; end
    else if (sx < -32768) begin scr_x = 16'h8000; cx = 1'b1; end
    else                        scr_x = sx[ScreenW-1:0];
    if (sy > 32767)       begin scr_y = 16'h7FFF; cy = 1'b1; end
    else if (sy < -32768) begin scr_y = 16'h8000; cy = 1'b1; end
    else                        scr_y = sy[ScreenW-1:0];
    if (sf.behind) begin
      scr_x = '0;
      scr_y = '0;
      cx = 1'b0;
      cy = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q.rotated_x     <= sf.rot.rx;
      out_q.rotated_y     <= sf.rot.ry;
      out_q.rotated_z     <= sf.rot.rz;
      out_q.screen_x      <= scr_x;
      out_q.screen_y      <= scr_y;
      out_q.behind_viewer <= sf.behind;
      out_q.saturated     <= sf.rot.sat | cx | cy;
      out_q.last_out      <= sf.rot.last;
    end
  end

  assign valid_o = vld_q[Lat-1];
  assign item_o  = out_q;

endmodule

### sv/vertex_rotate_project.sv
// Top level: config registers, rotation front, queue, projection back.
//
//  channel | dir | handshake           | payload
//  in      | in  | in_valid_i/in_stall_o   | in_data_i  (vrp_in_t)
//  out     | out | out_valid_o/out_stall_i | out_data_o (vrp_out_t)
//  cfg     | in  | cfg_we_i            | cfg_idx_i, cfg_data_i
//
// One item per cycle sustained while neither in_stall_o nor out_stall_i is high. Items
// pass rotation, queue, then projection (one quotient bit per stage of the divider).
// Reset clears all valid bits and loads the register defaults.
// The front stalls once queued plus in-flight items reach QDepth - 1;
// the back stalls as a whole while the output item is not taken.
`timescale 1ns / 1ps
module vertex_rotate_project
  import vrp_pkg::*;
#(
  parameter int ScreenWidth  = DefScreenWidth,
  parameter int ScreenHeight = DefScreenHeight
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  vrp_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output vrp_out_t            out_data_o,
  input  logic                cfg_we_i,
  input  logic [RegIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int QDepth = 8;

  // configuration registers
  vrp_cfg_t cfg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_cos  <= 16'sd16384;
      cfg_q.x_sin  <= '0;
      cfg_q.y_cos  <= 16'sd16384;
      cfg_q.y_sin  <= '0;
      cfg_q.z_cos  <= 16'sd16384;
      cfg_q.z_sin  <= '0;
      cfg_q.view_d <= 23'd128000;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_X_COS:  cfg_q.x_cos  <= cfg_data_i[TrigW-1:0];
        REG_X_SIN:  cfg_q.x_sin  <= cfg_data_i[TrigW-1:0];
        REG_Y_COS:  cfg_q.y_cos  <= cfg_data_i[TrigW-1:0];
        REG_Y_SIN:  cfg_q.y_sin  <= cfg_data_i[TrigW-1:0];
        REG_Z_COS:  cfg_q.z_cos  <= cfg_data_i[TrigW-1:0];
        REG_Z_SIN:  cfg_q.z_sin  <= cfg_data_i[TrigW-1:0];
        REG_VIEW_D: cfg_q.view_d <= cfg_data_i[DistW-1:0];
        default: ;
      endcase
    end
  end

  // front: runs freely, input accepted when the queue has room for all in flight
  logic     rot_valid;
  vrp_rot_t rot_item;
  logic     q_empty, q_pop;
  logic [$clog2(QDepth+1)-1:0] q_count;
  logic [2:0] inflight_q;
  logic in_acc;

  assign in_acc     = in_valid_i & ~in_stall_o;
  assign in_stall_o = (32'(q_count) + 32'($countones(inflight_q))) >= (QDepth - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) inflight_q <= '0;
    else         inflight_q <= {inflight_q[1:0], in_acc};
  end

  vrp_rotate u_rot (
    .clk_i, .rst_ni,
    .en_i    (1'b1),
    .valid_i (in_acc),
    .item_i  (in_data_i),
    .cfg_i   (cfg_q),
    .valid_o (rot_valid),
    .item_o  (rot_item)
  );

  vrp_rot_t q_data;
  vrp_fifo #(.Depth(QDepth)) u_fifo (
    .clk_i, .rst_ni,
    .push_i  (rot_valid),
    .data_i  (rot_item),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .count_o (q_count),
    .data_o  (q_data)
  );

  // back: whole pipeline advances unless the output item waits
  logic     back_en, proj_valid;
  vrp_out_t proj_item;
  assign back_en = ~(out_valid_o & out_stall_i);
  assign q_pop   = back_en & ~q_empty;

  vrp_project #(.ScreenWidth(ScreenWidth), .ScreenHeight(ScreenHeight)) u_proj (
    .clk_i, .rst_ni,
    .en_i     (back_en),
    .valid_i  (q_pop),
    .item_i   (q_data),
    .view_d_i (cfg_q.view_d),
    .valid_o  (proj_valid),
    .item_o   (proj_item)
  );

  assign out_valid_o = proj_valid;
  assign out_data_o  = proj_item;

`ifndef SYNTHESIS
  a_q_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rot_valid |-> (q_count < QDepth || q_pop))
    else $error("queue overflow");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output changed while stalled");
  a_behind_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.behind_viewer |->
      out_data_o.screen_x == '0 && out_data_o.screen_y == '0)
    else $error("behind viewer with nonzero screen position");
`endif

endmodule
